[hw/rtl/rec_pkg.sv]
// Shared types, constants and helpers for the reference-counted entry cache.
`timescale 1ns / 1ps
package rec_pkg;

    localparam int REF_W    = 16;
    localparam int SLOT_O_W = 5;
    localparam int NUM_I_W  = 16;
    localparam int LIMIT_W  = 17;

    localparam logic [REF_W-1:0] REFS_MAX = {REF_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_GET  = 2'd0,
        ACT_DUP  = 2'd1,
        ACT_PUT  = 2'd2,
        ACT_MARK = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOREF = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Broadcast command seen by every cell during the look-up cycle
    typedef struct packed {
        logic get_en;
        logic dup;
        logic put;
        logic mark;
        logic unlinked;
        logic any_hit;
    } cmd_t;

    // Flags and count rippled from cell to cell
    typedef struct packed {
        logic             hit;
        logic             free;
        logic             live;
        logic             claimed;
        logic             deleted;
        logic [REF_W-1:0] count;
    } chain_t;

    function automatic logic [REF_W-1:0] bump(input logic [REF_W-1:0] c);
        bump = (c == REFS_MAX) ? c : c + REF_W'(1);
    endfunction

endpackage

[hw/rtl/rec_cell.sv]
// One table slot: object number, reference count and loaded flag, with chain links.
`timescale 1ns / 1ps
module rec_cell #(
    parameter int NUMBER_BITS = 16,
    parameter int SLOT_W      = 5,
    parameter int IDX_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  rec_pkg::cmd_t             cmd,
    input  logic [NUMBER_BITS-1:0]    num,
    input  logic [IDX_W-1:0]          idx,
    input  rec_pkg::chain_t           chain_in,
    input  logic [SLOT_W-1:0]         slot_in,
    output rec_pkg::chain_t           chain_out,
    output logic [SLOT_W-1:0]         slot_out
);

    logic [NUMBER_BITS-1:0]       number_reg;
    logic [NUMBER_BITS-1:0]       number_next;
    logic [rec_pkg::REF_W-1:0]    refs_reg;
    logic [rec_pkg::REF_W-1:0]    refs_next;
    logic                         loaded_reg;
    logic                         loaded_next;

    logic live;
    logic my_hit;
    logic sel_hit;
    logic sel_claim;
    logic sel_idx;
    logic del;
    logic [rec_pkg::REF_W-1:0] count;

    assign live      = (refs_reg != '0);
    assign my_hit    = cmd.get_en && live && (number_reg == num);
    assign sel_hit   = my_hit && !chain_in.hit;
    assign sel_claim = cmd.get_en && !cmd.any_hit && !live && !chain_in.free;
    assign sel_idx   = (idx == IDX_W'(INDEX)) && live;

    always_comb
    begin
        number_next = number_reg;
        refs_next   = refs_reg;
        loaded_next = loaded_reg;
        del         = 1'b0;
        count       = '0;
        if (sel_hit)
        begin
            refs_next = rec_pkg::bump(refs_reg);
            count     = refs_next;
        end
        else if (sel_claim)
        begin
            number_next = num;
            refs_next   = rec_pkg::REF_W'(1);
            loaded_next = 1'b0;
            count       = refs_next;
        end
        else if (sel_idx && cmd.dup)
        begin
            refs_next = rec_pkg::bump(refs_reg);
            count     = refs_next;
        end
        else if (sel_idx && cmd.put)
        begin
            // last reference of a loaded, unlinked object: free and flag delete
            del       = (refs_reg == rec_pkg::REF_W'(1)) && loaded_reg && cmd.unlinked;
            refs_next = refs_reg - rec_pkg::REF_W'(1);
            if (refs_next == '0)
            begin
                loaded_next = 1'b0;
                number_next = '1;
            end
            count = refs_next;
        end
        else if (sel_idx && cmd.mark)
        begin
            loaded_next = 1'b1;
            count       = refs_reg;
        end
    end

    always_comb
    begin
        chain_out.hit     = chain_in.hit || my_hit;
        chain_out.free    = chain_in.free || !live;
        chain_out.live    = chain_in.live || sel_idx;
        chain_out.claimed = chain_in.claimed || sel_claim;
        chain_out.deleted = chain_in.deleted || del;
        chain_out.count   = chain_in.count | count;
        slot_out          = slot_in | ((sel_hit || sel_claim) ? SLOT_W'(INDEX) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refs_reg   <= '0;
            loaded_reg <= 1'b0;
        end
        else if (en)
        begin
            refs_reg   <= refs_next;
            loaded_reg <= loaded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            number_reg <= number_next;
        end
    end

endmodule

[hw/rtl/refcounted_entry_cache_core.sv]
// Top level of the reference-counted entry cache: request capture, slot chain, result register.
//
// Usage:
//   Requests: drive action, object_number, slot_index and links_are_zero with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Results: slot_out, status, newly_claimed, delete_needed and count_after are shown
//   for exactly one cycle with done high; the receiver cannot stall, so a result
//   not taken in that cycle is gone.
//   Sequence: an accepted request is registered and held through the look-up cycle; done is
//   registered at its end; no new request is taken while busy is high.
//   The look-up cycle ripples hit and free flags along the row of slot cells, one cell
//   per slot, and the table is updated at its end; that ripple sets the cycle time.
//   busy is high only during the look-up cycle, so the next request may be taken in
//   the cycle that shows the previous result.
//   Configuration: object_limit is written over cfg_valid/cfg_ready/cfg_data
//   (cfg_ready is always high); write it only while no request is in flight.
//   Reset: all slots hold no reference, object_limit returns to 65536, no result shows.
`timescale 1ns / 1ps
module refcounted_entry_cache_core #(
    parameter int SLOTS       = 32,
    parameter int NUMBER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [rec_pkg::NUM_I_W-1:0]     object_number,
    input  logic [rec_pkg::SLOT_O_W-1:0]    slot_index,
    input  logic                            links_are_zero,
    output logic                            done,
    output logic [rec_pkg::SLOT_O_W-1:0]    slot_out,
    output logic [1:0]                      status,
    output logic                            newly_claimed,
    output logic                            delete_needed,
    output logic [rec_pkg::REF_W-1:0]       count_after,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rec_pkg::LIMIT_W-1:0]     cfg_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = (SLOT_W > rec_pkg::SLOT_O_W) ? SLOT_W : rec_pkg::SLOT_O_W;
    localparam logic [32:0] NUM_MASK = 33'((64'd1 << NUMBER_BITS) - 64'd1);

    typedef enum logic {
        IDLE,
        LOOK
    } state_t;

    state_t                           state_reg;
    logic [rec_pkg::LIMIT_W-1:0]      limit_reg;
    rec_pkg::action_t                 action_reg;
    logic [NUMBER_BITS-1:0]           num_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic                             unlinked_reg;
    logic                             range_err_reg;

    logic                             done_reg;
    logic [rec_pkg::SLOT_O_W-1:0]     slot_out_reg;
    logic [rec_pkg::SLOT_O_W-1:0]     slot_out_next;
    rec_pkg::status_t                 status_reg;
    rec_pkg::status_t                 status_next;
    logic                             claimed_reg;
    logic                             deleted_reg;
    logic [rec_pkg::REF_W-1:0]        count_reg;

    logic                             accept;
    logic                             range_err;
    logic                             is_get;
    rec_pkg::cmd_t                    cmd;
    rec_pkg::chain_t                  link [SLOTS+1];
    logic [SLOT_W-1:0]                slot_link [SLOTS+1];
    logic [IDX_W-1:0]                 slot_wide;

    assign busy      = (state_reg == LOOK);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign range_err = ({1'b0, object_number} >= limit_reg) || (33'(object_number) > NUM_MASK);

    assign is_get       = (action_reg == rec_pkg::ACT_GET);
    assign cmd.get_en   = is_get && !range_err_reg;
    assign cmd.dup      = (action_reg == rec_pkg::ACT_DUP);
    assign cmd.put      = (action_reg == rec_pkg::ACT_PUT);
    assign cmd.mark     = (action_reg == rec_pkg::ACT_MARK);
    assign cmd.unlinked = unlinked_reg;
    assign cmd.any_hit  = link[SLOTS].hit;

    assign link[0]      = '0;
    assign slot_link[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        rec_cell #(
            .NUMBER_BITS (NUMBER_BITS),
            .SLOT_W      (SLOT_W),
            .IDX_W       (IDX_W),
            .INDEX       (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (busy),
            .cmd       (cmd),
            .num       (num_reg),
            .idx       (idx_reg),
            .chain_in  (link[i]),
            .slot_in   (slot_link[i]),
            .chain_out (link[i+1]),
            .slot_out  (slot_link[i+1])
        );
    end

    assign slot_wide = IDX_W'(slot_link[SLOTS]);

    always_comb
    begin
        slot_out_next = '0;
        status_next   = rec_pkg::ST_OK;
        if (is_get)
        begin
            if (range_err_reg)
            begin
                status_next = rec_pkg::ST_RANGE;
            end
            else if (!link[SLOTS].hit && !link[SLOTS].free)
            begin
                status_next = rec_pkg::ST_FULL;
            end
            else
            begin
                slot_out_next = slot_wide[rec_pkg::SLOT_O_W-1:0];
            end
        end
        else
        begin
            slot_out_next = idx_reg[rec_pkg::SLOT_O_W-1:0];
            if (!link[SLOTS].live)
            begin
                status_next = rec_pkg::ST_NOREF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= rec_pkg::LIMIT_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= LOOK;
                    end
                end
                LOOK:
                begin
                    state_reg <= IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // hold the request for the look-up cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg    <= rec_pkg::action_t'(action);
            num_reg       <= NUMBER_BITS'(object_number);
            idx_reg       <= IDX_W'(slot_index);
            unlinked_reg  <= links_are_zero;
            range_err_reg <= range_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            slot_out_reg <= slot_out_next;
            status_reg   <= status_next;
            claimed_reg  <= link[SLOTS].claimed;
            deleted_reg  <= link[SLOTS].deleted;
            count_reg    <= link[SLOTS].count;
        end
    end

    assign done          = done_reg;
    assign slot_out      = slot_out_reg;
    assign status        = status_reg;
    assign newly_claimed = claimed_reg;
    assign delete_needed = deleted_reg;
    assign count_after   = count_reg;

endmodule
